@@ hdl/okpt_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry peak tracker.
package okpt_pkg;

  localparam int CordicMax = 24;
  localparam int CxW       = 40;
  localparam int CzW       = 34;
  localparam int MulW      = 34;
  localparam int ProdW     = 68;
  localparam int InW       = 160;
  localparam int OutW      = 320;

  localparam logic signed [CzW-1:0]  PiQ29     = 34'sd1686629713;
  localparam logic signed [CzW-1:0]  HalfPiQ29 = 34'sd843314857;
  localparam logic signed [CxW-1:0]  GainQ30   = 40'sd652032874;
  localparam logic signed [MulW-1:0] Usec      = 34'sd1000000;
  localparam logic signed [MulW-1:0] Usec8     = 34'sd8000000;
  localparam logic signed [15:0]     PiQ13     = 16'sd25736;
  localparam logic signed [16:0]     TwoPiQ13  = 17'sd51472;

  // register indexes
  localparam logic CfgMinInterval  = 1'b0;
  localparam logic CfgSensorOffset = 1'b1;

  // divider phases
  localparam logic [1:0] PhSpeed = 2'd0;
  localparam logic [1:0] PhAccel = 2'd1;
  localparam logic [1:0] PhRate  = 2'd2;
  localparam logic [1:0] PhRacc  = 2'd3;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_Q1, OP_Q2, OP_Q3, OP_Q4, OP_VINIT, OP_CRUN, OP_YAW,
    OP_RINIT, OP_RFIN, OP_L1, OP_L2, OP_L3, OP_FIRST, OP_D1, OP_M1, OP_M2,
    OP_M3, OP_M4, OP_M5, OP_SRUN, OP_PMUL, OP_DINIT, OP_DRUN, OP_DFIN,
    OP_COMMIT, OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] ph;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic started;
    logic dt_ok;
    logic out_free;
  } stat_t;

  function automatic logic [29:0] atan_q29(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd421657428;
      5'd1:  r = 30'd248918915;
      5'd2:  r = 30'd131521918;
      5'd3:  r = 30'd66762579;
      5'd4:  r = 30'd33510843;
      5'd5:  r = 30'd16771758;
      5'd6:  r = 30'd8387925;
      5'd7:  r = 30'd4194219;
      5'd8:  r = 30'd2097141;
      5'd9:  r = 30'd1048575;
      5'd10: r = 30'd524288;
      5'd11: r = 30'd262144;
      5'd12: r = 30'd131072;
      5'd13: r = 30'd65536;
      5'd14: r = 30'd32768;
      5'd15: r = 30'd16384;
      5'd16: r = 30'd8192;
      5'd17: r = 30'd4096;
      5'd18: r = 30'd2048;
      5'd19: r = 30'd1024;
      5'd20: r = 30'd512;
      5'd21: r = 30'd256;
      5'd22: r = 30'd128;
      5'd23: r = 30'd64;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/okpt_ctrl.sv @@
// Sequencer of the odometry peak tracker: one-hot state machine issuing datapath commands.
module okpt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  okpt_pkg::stat_t      stat_i,
  output okpt_pkg::cmd_t       cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE   = 28'h0000001,
    S_Q1     = 28'h0000002,
    S_Q2     = 28'h0000004,
    S_Q3     = 28'h0000008,
    S_Q4     = 28'h0000010,
    S_VINIT  = 28'h0000020,
    S_VRUN   = 28'h0000040,
    S_YAW    = 28'h0000080,
    S_RINIT  = 28'h0000100,
    S_RRUN   = 28'h0000200,
    S_RFIN   = 28'h0000400,
    S_L1     = 28'h0000800,
    S_L2     = 28'h0001000,
    S_L3     = 28'h0002000,
    S_FIRST  = 28'h0004000,
    S_D1     = 28'h0008000,
    S_M1     = 28'h0010000,
    S_M2     = 28'h0020000,
    S_M3     = 28'h0040000,
    S_M4     = 28'h0080000,
    S_M5     = 28'h0100000,
    S_SRUN   = 28'h0200000,
    S_PMUL   = 28'h0400000,
    S_DINIT  = 28'h0800000,
    S_DRUN   = 28'h1000000,
    S_DFIN   = 28'h2000000,
    S_COMMIT = 28'h4000000,
    S_OUT    = 28'h8000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] ph_q, ph_d;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    cmd_o.op = okpt_pkg::OP_NOP;
    cmd_o.ph = ph_q;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.op = okpt_pkg::OP_LOAD;
          state_d  = S_Q1;
        end
      end
      S_Q1:    begin cmd_o.op = okpt_pkg::OP_Q1;    state_d = S_Q2;    end
      S_Q2:    begin cmd_o.op = okpt_pkg::OP_Q2;    state_d = S_Q3;    end
      S_Q3:    begin cmd_o.op = okpt_pkg::OP_Q3;    state_d = S_Q4;    end
      S_Q4:    begin cmd_o.op = okpt_pkg::OP_Q4;    state_d = S_VINIT; end
      S_VINIT: begin cmd_o.op = okpt_pkg::OP_VINIT; state_d = S_VRUN;  end
      S_VRUN: begin
        cmd_o.op = okpt_pkg::OP_CRUN;
        if (stat_i.last) state_d = S_YAW;
      end
      S_YAW:   begin cmd_o.op = okpt_pkg::OP_YAW;   state_d = S_RINIT; end
      S_RINIT: begin
        cmd_o.op = okpt_pkg::OP_RINIT;
        // too early: just repeat what is stored
        state_d  = (stat_i.started && !stat_i.dt_ok) ? S_OUT : S_RRUN;
      end
      S_RRUN: begin
        cmd_o.op = okpt_pkg::OP_CRUN;
        if (stat_i.last) state_d = S_RFIN;
      end
      S_RFIN:  begin cmd_o.op = okpt_pkg::OP_RFIN;  state_d = S_L1;    end
      S_L1:    begin cmd_o.op = okpt_pkg::OP_L1;    state_d = S_L2;    end
      S_L2:    begin cmd_o.op = okpt_pkg::OP_L2;    state_d = S_L3;    end
      S_L3: begin
        cmd_o.op = okpt_pkg::OP_L3;
        state_d  = stat_i.started ? S_D1 : S_FIRST;
      end
      S_FIRST: begin cmd_o.op = okpt_pkg::OP_FIRST; state_d = S_OUT;   end
      S_D1:    begin cmd_o.op = okpt_pkg::OP_D1;    state_d = S_M1;    end
      S_M1:    begin cmd_o.op = okpt_pkg::OP_M1;    state_d = S_M2;    end
      S_M2:    begin cmd_o.op = okpt_pkg::OP_M2;    state_d = S_M3;    end
      S_M3:    begin cmd_o.op = okpt_pkg::OP_M3;    state_d = S_M4;    end
      S_M4:    begin cmd_o.op = okpt_pkg::OP_M4;    state_d = S_M5;    end
      S_M5:    begin cmd_o.op = okpt_pkg::OP_M5;    state_d = S_SRUN;  end
      S_SRUN: begin
        cmd_o.op = okpt_pkg::OP_SRUN;
        if (stat_i.last) begin
          state_d = S_PMUL;
          ph_d    = okpt_pkg::PhSpeed;
        end
      end
      S_PMUL:  begin cmd_o.op = okpt_pkg::OP_PMUL;  state_d = S_DINIT; end
      S_DINIT: begin cmd_o.op = okpt_pkg::OP_DINIT; state_d = S_DRUN;  end
      S_DRUN: begin
        cmd_o.op = okpt_pkg::OP_DRUN;
        if (stat_i.last) state_d = S_DFIN;
      end
      S_DFIN: begin
        cmd_o.op = okpt_pkg::OP_DFIN;
        if (ph_q == okpt_pkg::PhRacc) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_PMUL;
          ph_d    = ph_q + 2'd1;
        end
      end
      S_COMMIT: begin cmd_o.op = okpt_pkg::OP_COMMIT; state_d = S_OUT; end
      S_OUT: begin
        cmd_o.op = okpt_pkg::OP_OUT;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  // one word at a time: no second accept right after the first
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second word accepted while busy");

  // result slot occupied: sequencer must hold in the output state
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !stat_i.out_free) |=> state_q == S_OUT)
    else $error("left output state with slot full");

endmodule

@@ hdl/okpt_datapath.sv @@
// Datapath: shared multiplier, CORDIC, square root and divider plus tracker state.
module okpt_datapath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  okpt_pkg::cmd_t               cmd_i,
  output okpt_pkg::stat_t              stat_o,
  input  logic [okpt_pkg::InW-1:0]     s_axis_tdata_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [19:0]                  cfg_data_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [okpt_pkg::OutW-1:0]    m_axis_tdata_o
);

  localparam int Steps = (CORDIC_STEPS > okpt_pkg::CordicMax) ? okpt_pkg::CordicMax
                                                              : CORDIC_STEPS;
  localparam logic [4:0] CLim = 5'(Steps - 1);
  localparam int MW = okpt_pkg::MulW;
  localparam int PW = okpt_pkg::ProdW;
  localparam int XW = okpt_pkg::CxW;
  localparam int ZW = okpt_pkg::CzW;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v[PW-1:31] == '0 || v[PW-1:31] == '1) r = v[31:0];
    else r = v[PW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    return r;
  endfunction

  function automatic logic signed [31:0] clampd(input logic signed [32:0] d);
    logic signed [31:0] r;
    if (!d[32] && d[31]) r = 32'sh7FFFFFFF;
    else if (d[32] && (!d[31] || d[30:0] == '0)) r = 32'sh80000001;
    else r = d[31:0];
    return r;
  endfunction

  function automatic logic [30:0] absu31(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return m[31] ? 31'h7FFFFFFF : m[30:0];
  endfunction

  // sample and configuration
  logic [31:0]        stamp_q;
  logic signed [31:0] px_q, py_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic [19:0]        min_int_q;
  logic [17:0]        offset_q;
  // tracker state
  logic               started_q;
  logic signed [31:0] last_x_q, last_y_q;
  logic signed [15:0] last_hd_q, yaw_q;
  logic [31:0]        last_stamp_q, dt_q;
  logic [30:0]        speed_now_q;
  logic signed [31:0] accel_now_q, rate_now_q, racc_now_q;
  logic [30:0]        peak_q [6];
  // work registers
  logic signed [MW-1:0] mul_a, mul_b, ax_q, co_q, si_q;
  logic signed [PW-1:0] prod_q, acc_q, sum_ap;
  logic signed [XW-1:0] cx_q, cy_q, sh_x, sh_y, cx_n, cy_n, vx, vy;
  logic signed [ZW-1:0] cz_q, cz_n, at, zr, zq;
  logic                 cmode_q, czero_q, cneg_q;
  logic [4:0]           cnt_q;
  logic signed [31:0]   nx_q, ny_q, ddx_q, ddy_q;
  logic [63:0]          sqv_q, sv_q, dmag;
  logic [33:0]          srem_q;
  logic [35:0]          st, strial;
  logic [31:0]          root_q, drem_q, dq_q;
  logic [32:0]          dt33;
  logic                 fwd_q, dneg_q, dovf_q, dge;
  logic [30:0]          spd_q;
  logic signed [31:0]   lacc_q, rate_q, racc_q, sres;
  logic signed [32:0]   dspd, drate, dx, dy;
  logic signed [16:0]   dyaw_raw, dyaw;
  logic signed [17:0]   yq;
  logic [19:0]          minv;
  logic                 out_valid_q, out_free;
  logic [okpt_pkg::OutW-1:0] out_data_q;

  assign sum_ap   = acc_q + prod_q;
  assign dspd     = $signed({2'b00, spd_q}) - $signed({2'b00, speed_now_q});
  assign drate    = 33'(rate_q) - 33'(rate_now_q);
  assign dyaw_raw = 17'(yaw_q) - 17'(last_hd_q);
  assign minv     = (min_int_q == '0) ? 20'd1 : min_int_q;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    if (dyaw_raw > 17'(okpt_pkg::PiQ13)) dyaw = dyaw_raw - okpt_pkg::TwoPiQ13;
    else if (dyaw_raw < -17'(okpt_pkg::PiQ13)) dyaw = dyaw_raw + okpt_pkg::TwoPiQ13;
    else dyaw = dyaw_raw;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      okpt_pkg::OP_Q1: begin mul_a = MW'(qy_q); mul_b = MW'(qy_q); end
      okpt_pkg::OP_Q2: begin mul_a = MW'(qz_q); mul_b = MW'(qz_q); end
      okpt_pkg::OP_Q3: begin mul_a = MW'(qw_q); mul_b = MW'(qz_q); end
      okpt_pkg::OP_Q4: begin mul_a = MW'(qx_q); mul_b = MW'(qy_q); end
      okpt_pkg::OP_L1: begin mul_a = $signed(MW'(offset_q)); mul_b = co_q; end
      okpt_pkg::OP_L2: begin mul_a = $signed(MW'(offset_q)); mul_b = si_q; end
      okpt_pkg::OP_M1: begin mul_a = MW'(ddx_q); mul_b = MW'(ddx_q); end
      okpt_pkg::OP_M2: begin mul_a = MW'(ddy_q); mul_b = MW'(ddy_q); end
      okpt_pkg::OP_M3: begin mul_a = MW'(ddx_q); mul_b = co_q; end
      okpt_pkg::OP_M4: begin mul_a = MW'(ddy_q); mul_b = si_q; end
      okpt_pkg::OP_PMUL: begin
        case (cmd_i.ph)
          okpt_pkg::PhSpeed: begin mul_a = $signed(MW'(root_q)); mul_b = okpt_pkg::Usec; end
          okpt_pkg::PhAccel: begin mul_a = MW'(dspd);  mul_b = okpt_pkg::Usec;  end
          okpt_pkg::PhRate:  begin mul_a = MW'(dyaw);  mul_b = okpt_pkg::Usec8; end
          default:           begin mul_a = MW'(drate); mul_b = okpt_pkg::Usec;  end
        endcase
      end
      default: ;
    endcase
  end

  // CORDIC micro-rotation; rotation mode steers on z, vectoring on y
  always_comb begin
    sh_x = cx_q >>> cnt_q;
    sh_y = cy_q >>> cnt_q;
    at   = $signed(ZW'(okpt_pkg::atan_q29(cnt_q)));
    if (cmode_q ? !cz_q[ZW-1] : cy_q[XW-1]) begin
      cx_n = cx_q - sh_y;
      cy_n = cy_q + sh_x;
      cz_n = cz_q - at;
    end else begin
      cx_n = cx_q + sh_y;
      cy_n = cy_q - sh_x;
      cz_n = cz_q + at;
    end
  end

  assign vx     = XW'(ax_q);
  assign vy     = XW'($signed({sum_ap[MW-2:0], 1'b0}));
  assign zr     = $signed({{2{(started_q ? last_hd_q[15] : yaw_q[15])}},
                           (started_q ? last_hd_q : yaw_q), 16'h0000});
  assign zq     = cz_q + 34'sd32768;
  assign yq     = zq[ZW-1:16];
  assign st     = {srem_q, sv_q[63:62]};
  assign strial = {2'b00, root_q, 2'b01};
  assign dmag   = prod_q[PW-1] ? 64'(-prod_q) : 64'(prod_q);
  assign dt33   = {1'b0, dt_q};
  assign dge    = {drem_q, dq_q[31]} >= dt33;

  always_comb begin
    if (dneg_q) sres = (dovf_q || (dq_q[31] && dq_q[30:0] != '0)) ? 32'sh80000000
                                                                  : -$signed(dq_q);
    else sres = (dovf_q || dq_q[31]) ? 32'sh7FFFFFFF : $signed(dq_q);
  end

  // work registers (no reset)
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      okpt_pkg::OP_LOAD: begin
        stamp_q <= s_axis_tdata_i[31:0];
        px_q    <= s_axis_tdata_i[63:32];
        py_q    <= s_axis_tdata_i[95:64];
        qx_q    <= s_axis_tdata_i[111:96];
        qy_q    <= s_axis_tdata_i[127:112];
        qz_q    <= s_axis_tdata_i[143:128];
        qw_q    <= s_axis_tdata_i[159:144];
      end
      okpt_pkg::OP_Q2: acc_q <= prod_q;
      okpt_pkg::OP_Q3: acc_q <= sum_ap;
      okpt_pkg::OP_Q4: begin
        ax_q  <= 34'sd1073741824 - $signed({acc_q[MW-2:0], 1'b0});
        acc_q <= prod_q;
      end
      okpt_pkg::OP_VINIT: begin
        cmode_q <= 1'b0;
        czero_q <= (vx == '0) && (vy == '0);
        cnt_q   <= '0;
        if (vx < 0) begin
          if (vy >= 0) begin
            cx_q <= vy; cy_q <= -vx; cz_q <= okpt_pkg::HalfPiQ29;
          end else begin
            cx_q <= -vy; cy_q <= vx; cz_q <= -okpt_pkg::HalfPiQ29;
          end
        end else begin
          cx_q <= vx; cy_q <= vy; cz_q <= '0;
        end
      end
      okpt_pkg::OP_CRUN: begin
        cx_q  <= cx_n;
        cy_q  <= cy_n;
        cz_q  <= cz_n;
        cnt_q <= cnt_q + 5'd1;
      end
      okpt_pkg::OP_YAW: begin
        if (czero_q) yaw_q <= '0;
        else if (yq > 18'(okpt_pkg::PiQ13)) yaw_q <= okpt_pkg::PiQ13;
        else if (yq < -18'(okpt_pkg::PiQ13)) yaw_q <= -okpt_pkg::PiQ13;
        else yaw_q <= yq[15:0];
        dt_q <= stamp_q - last_stamp_q;
      end
      okpt_pkg::OP_RINIT: begin
        cmode_q <= 1'b1;
        cnt_q   <= '0;
        cx_q    <= okpt_pkg::GainQ30;
        cy_q    <= '0;
        if (zr > okpt_pkg::HalfPiQ29) begin
          cz_q <= zr - okpt_pkg::PiQ29; cneg_q <= 1'b1;
        end else if (zr < -okpt_pkg::HalfPiQ29) begin
          cz_q <= zr + okpt_pkg::PiQ29; cneg_q <= 1'b1;
        end else begin
          cz_q <= zr; cneg_q <= 1'b0;
        end
      end
      okpt_pkg::OP_RFIN: begin
        co_q <= cneg_q ? -MW'(cx_q) : MW'(cx_q);
        si_q <= cneg_q ? -MW'(cy_q) : MW'(cy_q);
      end
      okpt_pkg::OP_L2: nx_q <= sat32(PW'(px_q) - ((prod_q + 68'sd536870912) >>> 30));
      okpt_pkg::OP_L3: ny_q <= sat32(PW'(py_q) - ((prod_q + 68'sd536870912) >>> 30));
      okpt_pkg::OP_D1: begin
        ddx_q <= clampd(dx);
        ddy_q <= clampd(dy);
      end
      okpt_pkg::OP_M2: acc_q <= prod_q;
      okpt_pkg::OP_M3: sqv_q <= 64'(sum_ap);
      okpt_pkg::OP_M4: acc_q <= prod_q;
      okpt_pkg::OP_M5: begin
        fwd_q  <= sum_ap > 0;
        sv_q   <= sqv_q;
        srem_q <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      okpt_pkg::OP_SRUN: begin
        if (st >= strial) begin
          srem_q <= 34'(st - strial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= st[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
        sv_q  <= {sv_q[61:0], 2'b00};
        cnt_q <= cnt_q + 5'd1;
      end
      okpt_pkg::OP_DINIT: begin
        dneg_q <= prod_q[PW-1];
        dovf_q <= dmag[63:32] >= dt_q;
        drem_q <= dmag[63:32];
        dq_q   <= dmag[31:0];
        cnt_q  <= '0;
      end
      okpt_pkg::OP_DRUN: begin
        drem_q <= dge ? 32'({drem_q, dq_q[31]} - dt33) : {drem_q[30:0], dq_q[31]};
        dq_q   <= {dq_q[30:0], dge};
        cnt_q  <= cnt_q + 5'd1;
      end
      okpt_pkg::OP_DFIN: begin
        case (cmd_i.ph)
          okpt_pkg::PhSpeed: spd_q <= (dovf_q || dq_q[31]) ? 31'h7FFFFFFF : dq_q[30:0];
          okpt_pkg::PhAccel: lacc_q <= sres;
          okpt_pkg::PhRate:  rate_q <= sres;
          default:           racc_q <= sres;
        endcase
      end
      default: ;
    endcase
  end

  assign dx = 33'(nx_q) - 33'(last_x_q);
  assign dy = 33'(ny_q) - 33'(last_y_q);

  // tracker state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q    <= 20'd200000;
      offset_q     <= 18'd16384;
      started_q    <= 1'b0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_hd_q    <= '0;
      last_stamp_q <= '0;
      speed_now_q  <= '0;
      accel_now_q  <= '0;
      rate_now_q   <= '0;
      racc_now_q   <= '0;
      for (int k = 0; k < 6; k++) peak_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          okpt_pkg::CfgMinInterval:  min_int_q <= cfg_data_i;
          okpt_pkg::CfgSensorOffset: offset_q  <= cfg_data_i[17:0];
          default: ;
        endcase
      end
      if (cmd_i.op == okpt_pkg::OP_FIRST || cmd_i.op == okpt_pkg::OP_COMMIT) begin
        started_q    <= 1'b1;
        last_x_q     <= nx_q;
        last_y_q     <= ny_q;
        last_hd_q    <= yaw_q;
        last_stamp_q <= stamp_q;
      end
      if (cmd_i.op == okpt_pkg::OP_COMMIT) begin
        speed_now_q <= spd_q;
        accel_now_q <= lacc_q;
        rate_now_q  <= rate_q;
        racc_now_q  <= racc_q;
        if (fwd_q) begin
          if (spd_q > peak_q[0]) peak_q[0] <= spd_q;
          if (lacc_q > $signed({1'b0, peak_q[3]})) peak_q[3] <= lacc_q[30:0];
        end else begin
          if (spd_q > peak_q[1]) peak_q[1] <= spd_q;
          if (lacc_q > $signed({1'b0, peak_q[4]})) peak_q[4] <= lacc_q[30:0];
        end
        if (absu31(rate_q) > peak_q[2]) peak_q[2] <= absu31(rate_q);
        if (absu31(racc_q) > peak_q[5]) peak_q[5] <= absu31(racc_q);
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == okpt_pkg::OP_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == okpt_pkg::OP_OUT && out_free) begin
      out_data_q <= {7'b0, racc_now_q, rate_now_q, accel_now_q, speed_now_q,
                     peak_q[5], peak_q[4], peak_q[3], peak_q[2], peak_q[1], peak_q[0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign stat_o.last     = cnt_q == ((cmd_i.op == okpt_pkg::OP_CRUN) ? CLim : 5'd31);
  assign stat_o.started  = started_q;
  assign stat_o.dt_ok    = dt_q >= 32'(minv);
  assign stat_o.out_free = out_free;

  a_started_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  a_peak_speed_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> peak_q[0] >= $past(peak_q[0]))
    else $error("forward speed peak decreased");

  a_peak_turn_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> peak_q[2] >= $past(peak_q[2]))
    else $error("turn rate peak decreased");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == okpt_pkg::OP_OUT))
    else $error("result word raised outside output step");

endmodule

@@ hdl/odometry_kinematic_peak_tracker_unit.sv @@
// Top level of the odometry kinematic peak tracker: sequencer plus datapath.
//
//  port group | dir | word / fields (low bit up)
//  -----------+-----+---------------------------------------------------------
//  s_axis     | in  | stamp_us 32, pos_x 32, pos_y 32, quat_x/y/z/w 16 each
//  m_axis     | out | 6 peaks 31 each, now_speed 31, now_accel/turn_rate/
//             |     | turn_accel 32 each, 7 zero bits
//  cfg        | in  | idx 0 min_interval_us (20b), idx 1 sensor_offset (18b)
//
// One sample at a time; each CORDIC pass runs N = min(CORDIC_STEPS, 24) steps.
// A sample that is too early runs only the vectoring pass, the first sample
// also the rotation pass, an updating sample also the 32-step square root and
// the four 32-step divisions through the shared units.
// Reset clears the tracker state and loads the register defaults.
// A new sample is taken while the previous result word still waits; the
// sequencer holds only when it needs to write a new result into a full slot.
module odometry_kinematic_peak_tracker_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // stamp_us, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  input  logic [159:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // max_forward_speed, max_backward_speed, max_turn_rate, max_forward_accel,
  // max_backward_accel, max_turn_accel, now_speed, now_accel, now_turn_rate,
  // now_turn_accel, zero fill
  output logic [319:0] m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [19:0]  cfg_data_i
);

  okpt_pkg::cmd_t  cmd;
  okpt_pkg::stat_t stat;

  okpt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  okpt_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the odometry kinematic peak tracker unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int    STEPS      = 16;
  localparam longint HALF_PI   = 64'sd843314857;
  localparam longint PI_Z      = 64'sd1686629713;
  localparam longint GAIN      = 64'sd652032874;
  localparam longint PI_YAW    = 64'sd25736;
  localparam longint TWO_PI_YAW = 64'sd51472;
  localparam longint USEC      = 64'sd1000000;
  localparam longint MAX32     = 64'sd2147483647;
  localparam longint MIN32     = -64'sd2147483648;
  localparam int    SETTLE     = 250;   // worst-case sample latency, plus slack
  localparam int    IDLE_PCT   = 21;

  // one result word: ten fields, low 31 or 32 bits of each slot used
  typedef logic [9:0][31:0] peak_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // stamp_us, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  logic [159:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // 6 peaks, now_speed, now_accel, now_turn_rate, now_turn_accel, zero fill
  logic [319:0] m_axis_tdata_o;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [19:0]  cfg_data_i = '0;

  odometry_kinematic_peak_tracker_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker model: its own copy of registers and state
  // ---------------------------------------------------------------------------
  longint       arc_tab [24] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};

  logic [19:0]  gate_us;
  logic [17:0]  lever_arm;
  bit           trk_live;
  longint       trk_x, trk_y, trk_yaw;
  logic [31:0]  trk_stamp;
  longint       cur_speed, cur_accel, cur_rate, cur_racc;
  longint       peaks [6];

  peak_word_t   pending_words [$];
  int           words_seen, mismatches, updates_seen, fwd_seen, bwd_seen;
  bit           calm;   // no idling on either side while set

  function automatic longint sat_s32(longint v);
    return v > MAX32 ? MAX32 : (v < MIN32 ? MIN32 : v);
  endfunction

  function automatic longint sat_u31(longint v);
    return v > MAX32 ? MAX32 : (v < 0 ? 64'sd0 : v);
  endfunction

  // vectoring CORDIC: atan2(y, x) in Q3.13
  function automatic longint yaw_q13(longint x, longint y);
    longint z, t, a, b, q;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      a = y >>> i;
      b = x >>> i;
      if (y >= 0) begin
        x += a; y -= b; z += arc_tab[i];
      end else begin
        x -= a; y += b; z -= arc_tab[i];
      end
    end
    q = (z + 32768) >>> 16;
    if (q > PI_YAW) q = PI_YAW;
    if (q < -PI_YAW) q = -PI_YAW;
    return q;
  endfunction

  // rotation CORDIC: Q30 cos / sin of a Q3.13 heading
  function automatic void heading_trig(input longint h, output longint c,
                                       output longint s);
    longint z, x, y, a, b;
    bit     flip;
    z = h * 65536; x = GAIN; y = 0; flip = 0;
    if (z > HALF_PI) begin
      z -= PI_Z; flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI_Z; flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      a = y >>> i;
      b = x >>> i;
      if (z >= 0) begin
        x -= a; y += b; z -= arc_tab[i];
      end else begin
        x += a; y -= b; z += arc_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint arm_fix(longint p, longint trig);
    return sat_s32(p - ((longint'(lever_arm) * trig + (64'sd1 << 29)) >>> 30));
  endfunction

  function automatic longint disp_clamp(longint d);
    return d > MAX32 ? MAX32 : (d < -MAX32 ? -MAX32 : d);
  endfunction

  // next result word for one accepted sample; advances the tracker state
  function automatic peak_word_t track_pose(logic [159:0] w);
    peak_word_t      r;
    longint          px, py, qx, qy, qz, qw, yaw, co, si, nx, ny, ddx, ddy;
    longint          spd, acc, dyaw, rate, racc, dti, mag;
    longint unsigned span;
    logic [31:0]     dt, gate;
    px = longint'($signed(w[63:32]));
    py = longint'($signed(w[95:64]));
    qx = longint'($signed(w[111:96]));
    qy = longint'($signed(w[127:112]));
    qz = longint'($signed(w[143:128]));
    qw = longint'($signed(w[159:144]));
    yaw = yaw_q13((64'sd1 << 30) - 2 * (qy * qy + qz * qz), 2 * (qw * qz + qx * qy));
    if (!trk_live) begin
      heading_trig(yaw, co, si);
      trk_x = arm_fix(px, co);
      trk_y = arm_fix(py, si);
      trk_yaw = yaw;
      trk_stamp = w[31:0];
      trk_live = 1;
      return '0;
    end
    dt = w[31:0] - trk_stamp;
    gate = (gate_us == 0) ? 32'd1 : {12'd0, gate_us};
    if (dt >= gate) begin
      dti = longint'({32'd0, dt});
      updates_seen++;
      heading_trig(trk_yaw, co, si);
      nx = arm_fix(px, co);
      ny = arm_fix(py, si);
      ddx = disp_clamp(nx - trk_x);
      ddy = disp_clamp(ny - trk_y);
      span = root_floor(longint'(ddx * ddx) + longint'(ddy * ddy));
      spd = sat_u31(longint'(span * 64'd1000000 / longint'(dti)));
      acc = sat_s32((spd - cur_speed) * USEC / dti);
      // forward only when the displacement projects strictly ahead of the heading
      if (ddx * co + ddy * si > 0) begin
        fwd_seen++;
        if (spd > peaks[0]) peaks[0] = spd;
        if (acc > peaks[3]) peaks[3] = acc;
      end else begin
        bwd_seen++;
        if (spd > peaks[1]) peaks[1] = spd;
        if (acc > peaks[4]) peaks[4] = acc;
      end
      cur_speed = spd;
      cur_accel = acc;
      dyaw = yaw - trk_yaw;
      if (dyaw > PI_YAW) dyaw -= TWO_PI_YAW;
      else if (dyaw < -PI_YAW) dyaw += TWO_PI_YAW;
      rate = sat_s32(dyaw * 8 * USEC / dti);
      racc = sat_s32((rate - cur_rate) * USEC / dti);
      mag = sat_u31(rate < 0 ? -rate : rate);
      if (mag > peaks[2]) peaks[2] = mag;
      mag = sat_u31(racc < 0 ? -racc : racc);
      if (mag > peaks[5]) peaks[5] = mag;
      cur_rate = rate;
      cur_racc = racc;
      trk_x = nx;
      trk_y = ny;
      trk_yaw = yaw;
      trk_stamp = w[31:0];
    end
    for (int j = 0; j < 6; j++) r[j] = peaks[j][31:0];
    r[6] = cur_speed[31:0];
    r[7] = cur_accel[31:0];
    r[8] = cur_rate[31:0];
    r[9] = cur_racc[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure at the falling edge, check at the rising
  // ---------------------------------------------------------------------------
  always @(negedge clk_i)
    m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    peak_word_t exp_w;
    logic [31:0] got, mask;
    int          off;
    bit          bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with nothing expected");
      end else begin
        exp_w = pending_words.pop_front();
        bad = 0;
        for (int f = 0; f < 10; f++) begin
          // peaks and now_speed are 31 bits wide, the rest 32
          off  = (f < 7) ? 31 * f : 217 + 32 * (f - 7);
          mask = (f < 7) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
          got  = 32'(m_axis_tdata_o >> off) & mask;
          if (got !== (exp_w[f] & mask)) begin
            bad = 1;
            if (mismatches < 10)
              $display("ERROR: word %0d field %0d expected %h got %h",
                       words_seen, f, exp_w[f] & mask, got);
          end
        end
        if (bad) mismatches++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------
  // Drive one sample word; valid stays high into the next call for back-to-back
  task automatic send_pose(input logic [31:0] stamp, input logic [31:0] px,
                           input logic [31:0] py, input logic [15:0] qx,
                           input logic [15:0] qy, input logic [15:0] qz,
                           input logic [15:0] qw);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {qw, qz, qy, qx, py, px, stamp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_words.push_back(track_pose(s_axis_tdata_i));
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register writes only once the unit has gone quiet
  task automatic set_register(input logic idx, input logic [19:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == okpt_pkg::CfgMinInterval) gate_us = val;
    else lever_arm = val[17:0];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // first sample after reset latches state and yields an all-zero word
  task automatic test_first_sample;
    send_pose(32'd100, 32'h0001_0000, 32'h0002_0000, 16'd0, 16'd0, 16'd0, 16'h7FFF);
  endtask

  // default 200 ms gate: just short, exactly reached, then stamp going backwards
  task automatic test_interval_gate;
    send_pose(32'd200099, 32'h0003_0000, 32'h0002_0000, 16'd0, 16'd0, 16'd0, 16'h7FFF);
    send_pose(32'd200100, 32'h0003_0000, 32'h0002_0000, 16'd0, 16'd0, 16'h2000, 16'h7000);
    send_pose(32'd5, 32'h0000_8000, 32'hFFFF_0000, 16'd0, 16'd0, 16'h8000, 16'd0);
  endtask

  // degenerate and extreme quaternions, huge jumps that saturate displacements
  task automatic test_extremes;
    send_pose(32'd600000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pose(32'd900000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000);
    send_pose(32'd1200000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 16'h7FFF);
    send_pose(32'd1500000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000,
              16'h0000, 16'h8000);
    send_pose(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h7FFF,
              16'h0000, 16'h0000);
    send_pose(32'd400000, 32'h0000_1000, 32'h0000_2000, 16'h0000, 16'h0000,
              16'h5A82, 16'hA57E);
  endtask

  // register extremes: zero gate acts as one microsecond, lever arm 0 and 131072
  task automatic test_config_sweep;
    logic [31:0] st;
    st = 32'd500000;
    set_register(okpt_pkg::CfgMinInterval, 20'd0);
    set_register(okpt_pkg::CfgSensorOffset, 20'd0);
    for (int k = 0; k < 3; k++) begin
      st += k;   // same stamp first, then steps of one and two microseconds
      send_pose(st, 32'(k * 65536), 32'(-k * 32768), 16'd0, 16'd0, 16'h3000, 16'h7000);
    end
    set_register(okpt_pkg::CfgSensorOffset, 20'd131072);
    set_register(okpt_pkg::CfgMinInterval, 20'd1000000);
    send_pose(st + 999999, 32'h0010_0000, 32'h0, 16'd0, 16'd0, 16'hC000, 16'h6000);
    send_pose(st + 1000002, 32'h0020_0000, 32'h0, 16'd0, 16'd0, 16'h4000, 16'h6000);
    set_register(okpt_pkg::CfgMinInterval, 20'hFFFFF);
    send_pose(st + 2048578, 32'h0030_0000, 32'h0, 16'd0, 16'd0, 16'h0, 16'h7FFF);
    set_register(okpt_pkg::CfgMinInterval, 20'd1);
    send_pose(st + 2048579, 32'h0030_0100, 32'h0, 16'd0, 16'd0, 16'h100, 16'h7FFF);
  endtask

  // mostly smooth tracks with random motion and heading, some raw noise
  task automatic test_random_track(input int count);
    longint      px, py;
    logic [31:0] st;
    logic [15:0] qz, qw;
    int          gate;
    px = 0; py = 0; st = $urandom; gate = 1000; qz = 0; qw = 16'h7FFF;
    for (int n = 0; n < count; n++) begin
      calm = (n >= 300 && n < 450);
      if (n % 150 == 0) begin
        gate = $urandom_range(1, 5000);
        set_register(okpt_pkg::CfgMinInterval, 20'(gate));
        set_register(okpt_pkg::CfgSensorOffset, 20'($urandom_range(0, 131072)));
      end
      if ($urandom_range(0, 99) < 12) begin
        send_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end else begin
        st += $urandom_range(0, 2 * gate);
        px += longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        py += longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        if ($urandom_range(0, 3) == 0) begin
          qz = 16'($urandom); qw = 16'($urandom);
        end else begin
          qz += 16'($urandom_range(0, 2048)) - 16'd1024;
        end
        send_pose(st, px[31:0], py[31:0], 16'($urandom_range(0, 255)) - 16'd128,
                  16'($urandom_range(0, 255)) - 16'd128, qz, qw);
      end
    end
    calm = 0;
  endtask

  initial begin
    gate_us = 20'd200000; lever_arm = 18'd16384; trk_live = 0;
    trk_x = 0; trk_y = 0; trk_yaw = 0; trk_stamp = 0;
    cur_speed = 0; cur_accel = 0; cur_rate = 0; cur_racc = 0;
    foreach (peaks[j]) peaks[j] = 0;
    words_seen = 0; mismatches = 0; updates_seen = 0; fwd_seen = 0; bwd_seen = 0;
    calm = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_sample();
    test_interval_gate();
    test_extremes();
    test_config_sweep();
    test_random_track(880);
    drain();

    $display("Checked %0d result words; %0d samples updated the estimates", words_seen,
             updates_seen);
    $display("Motion split: %0d forward, %0d backward; %0d mismatching words", fwd_seen,
             bwd_seen, mismatches);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("PASS odometry_kinematic_peak_tracker_unit");
    else
      $display("FAIL odometry_kinematic_peak_tracker_unit");
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #40ms;
    $display("Timeout with %0d words outstanding", pending_words.size());
    $display("FAIL odometry_kinematic_peak_tracker_unit");
    $finish;
  end

endmodule
